@@ hdl/gvsf_pkg.sv @@
package gvsf_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(PIX_DEPTH);
  localparam int DIM_W      = 7;
  localparam int IDX_W      = 6;
  localparam int HSUM_W     = 18;
  localparam int ENERGY_W   = 19;
  localparam int TOTAL_W    = 25;

  // register indexes on the configuration port
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // phase codes inside one energy or walk step
  localparam logic [2:0] PH_0 = 3'd0;
  localparam logic [2:0] PH_1 = 3'd1;
  localparam logic [2:0] PH_2 = 3'd2;
  localparam logic [2:0] PH_3 = 3'd3;
  localparam logic [2:0] PH_4 = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ENERGY,
    B_WALK,
    B_EMIT_RD,
    B_EMIT_WT
  } back_state_t;

  function automatic logic [HSUM_W-1:0] sq_diff(input logic [23:0] a, input logic [23:0] b);
    logic [7:0]        x;
    logic [7:0]        y;
    logic [7:0]        d;
    logic [15:0]       p;
    logic [HSUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      x = a[8*i +: 8];
      y = b[8*i +: 8];
      d = (x > y) ? x - y : y - x;
      p = d * d;
      s = s + {2'b00, p};
    end
    return s;
  endfunction

  function automatic logic [AW-1:0] pix_addr(input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col,
                                             input logic [DIM_W-1:0] w);
    logic [AW:0] t;
    t = AW'(row * w) + {{(AW+1-IDX_W){1'b0}}, col};
    return t[AW-1:0];
  endfunction

endpackage

@@ hdl/greedy_vertical_seam_finder.sv @@
// After the last pixel of a w x h image, an energy pass runs over all pixels, then
// greedy walks from each start column and a recording walk, then one result per row.
// Throughput: one pixel per cycle when full is low; the next image may load once the
// energy pass of the previous one has released the pixel memory (single read port).
// Reset (synchronous, active high): size 64 x 64, load count, job queue, output empty.
module greedy_vertical_seam_finder
  import gvsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic               empty,
  input  logic               pop,
  output logic [IDX_W-1:0]   seam_column,
  output logic [IDX_W-1:0]   seam_row,
  output logic [TOTAL_W-1:0] seam_total_energy,
  output logic               last_row,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [DIM_W-1:0] img_w, img_h;
  logic             cfg_wr;
  logic [DIM_W-1:0] wval;
  logic             jq_full, jq_empty, job_push, job_pop, pix_release;
  job_t             job_in, job_out;
  logic [AW-1:0]    pix_raddr;
  logic [23:0]      pix_q;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] mx);
    if (v == '0) return DIM_W'(1);
    if (v > mx) return mx;
    return v;
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign wval   = pwdata[DIM_W-1:0];
  assign prdata = {25'd0, (paddr[2] == CFG_HEIGHT) ? img_h : img_w};

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= DIM_W'(MAX_WIDTH);
      img_h <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_WIDTH:  img_w <= clamp_dim(wval, DIM_W'(MAX_WIDTH));
        CFG_HEIGHT: img_h <= clamp_dim(wval, DIM_W'(MAX_HEIGHT));
        default:    img_w <= img_w;
      endcase
    end
  end

  gvsf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .cfg_clear   (cfg_wr),
    .img_w       (img_w),
    .img_h       (img_h),
    .pix_release (pix_release),
    .pix_raddr   (pix_raddr),
    .pix_q       (pix_q),
    .jq_full     (jq_full),
    .job_push    (job_push),
    .job         (job_in)
  );

  gvsf_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (jq_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (jq_empty)
  );

  gvsf_back u_back (
    .clk               (clk),
    .rst               (rst),
    .jq_empty          (jq_empty),
    .job               (job_out),
    .job_pop           (job_pop),
    .pix_raddr         (pix_raddr),
    .pix_q             (pix_q),
    .pix_release       (pix_release),
    .empty             (empty),
    .pop               (pop),
    .seam_column       (seam_column),
    .seam_row          (seam_row),
    .seam_total_energy (seam_total_energy),
    .last_row          (last_row)
  );

endmodule

@@ hdl/gvsf_front.sv @@
module gvsf_front
  import gvsf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  input  logic             cfg_clear,
  input  logic [DIM_W-1:0] img_w,
  input  logic [DIM_W-1:0] img_h,
  input  logic             pix_release,
  input  logic [AW-1:0]    pix_raddr,
  output logic [23:0]      pix_q,
  input  logic             jq_full,
  output logic             job_push,
  output job_t             job
);

  logic [AW:0]   load_count;
  logic          lock;
  logic [AW:0]   n_pix;
  logic          acc;
  logic          last;
  logic [23:0]   mem [PIX_DEPTH];

  assign n_pix    = (AW+1)'(img_w * img_h);
  assign full     = lock | jq_full;
  assign acc      = push & ~full;
  assign last     = (load_count + 1'b1) == n_pix;
  assign job_push = acc & last;
  assign job.w    = img_w;
  assign job.h    = img_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      lock       <= 1'b0;
    end else begin
      if (cfg_clear) begin
        load_count <= '0;
      end else if (acc) begin
        load_count <= last ? '0 : load_count + 1'b1;
      end
      // pixel store belongs to the back end until its energy pass is done
      if (job_push) begin
        lock <= 1'b1;
      end else if (pix_release) begin
        lock <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mem[load_count[AW-1:0]] <= {blue, green, red};
    end
    pix_q <= mem[pix_raddr];
  end

endmodule

@@ hdl/gvsf_jobq.sv @@
module gvsf_jobq
  import gvsf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wp <= ~wp;
      end
      if (pop && !empty) begin
        rp <= ~rp;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wp] <= din;
    end
  end

endmodule

@@ hdl/gvsf_back.sv @@
module gvsf_back
  import gvsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               jq_empty,
  input  job_t               job,
  output logic               job_pop,
  output logic [AW-1:0]      pix_raddr,
  input  logic [23:0]        pix_q,
  output logic               pix_release,
  output logic               empty,
  input  logic               pop,
  output logic [IDX_W-1:0]   seam_column,
  output logic [IDX_W-1:0]   seam_row,
  output logic [TOTAL_W-1:0] seam_total_energy,
  output logic               last_row
);

  back_state_t state, state_next;

  logic [DIM_W-1:0]    jw, jh;
  logic [2:0]          ph;
  logic [IDX_W-1:0]    er, ec;
  logic [AW-1:0]       eidx;
  logic [23:0]         pa, pc;
  logic [HSUM_W-1:0]   hsum;
  logic [ENERGY_W-1:0] e_wdata;
  logic                e_we;
  logic [AW-1:0]       e_raddr;
  logic [ENERGY_W-1:0] e_q;
  logic [ENERGY_W-1:0] emem [PIX_DEPTH];

  logic [IDX_W-1:0]    start, col, row;
  logic [TOTAL_W-1:0]  total, best_total;
  logic [IDX_W-1:0]    best_start;
  logic                recording;
  logic [ENERGY_W-1:0] fwd, up;

  logic [IDX_W-1:0]    path [MAX_HEIGHT];
  logic [IDX_W-1:0]    path_q;
  logic [IDX_W-1:0]    k;
  logic                ovalid;

  logic [IDX_W-1:0]    cl, cr, ru, rd;
  logic                last_pix;
  logic                has_up, has_dn;
  logic [ENERGY_W-1:0] pick;
  logic [IDX_W-1:0]    next_col;
  logic [TOTAL_W-1:0]  tot_new;
  logic                row_end, start_end, better;
  logic [TOTAL_W-1:0]  nb_total;
  logic [IDX_W-1:0]    nb_start;
  logic                step_end, emit_load;

  // wrapped neighbors for the energy pass
  assign cr = ({1'b0, ec} + 7'd1 == jw) ? '0 : ec + 1'b1;
  assign cl = (ec == '0) ? IDX_W'(jw - 7'd1) : ec - 1'b1;
  assign rd = ({1'b0, er} + 7'd1 == jh) ? '0 : er + 1'b1;
  assign ru = (er == '0) ? IDX_W'(jh - 7'd1) : er - 1'b1;
  assign last_pix = ({1'b0, ec} == jw - 7'd1) && ({1'b0, er} == jh - 7'd1);

  always_comb begin
    unique case (ph)
      PH_0:    pix_raddr = pix_addr(er, cr, jw);
      PH_1:    pix_raddr = pix_addr(er, cl, jw);
      PH_2:    pix_raddr = pix_addr(rd, ec, jw);
      default: pix_raddr = pix_addr(ru, ec, jw);
    endcase
  end

  assign e_wdata = {1'b0, hsum} + {1'b0, sq_diff(pc, pix_q)};
  assign e_we    = (state == B_ENERGY) && (ph == PH_4);

  always_comb begin
    unique case (ph)
      PH_0:    e_raddr = pix_addr(row, col, jw);
      PH_1:    e_raddr = pix_addr(row, col + 1'b1, jw);
      default: e_raddr = pix_addr(row, col - 1'b1, jw);
    endcase
  end

  // greedy step; the third read arrives in phase 3
  assign has_up = (row != '0) && ({1'b0, col} + 7'd1 < jw);
  assign has_dn = (row != '0) && (col != '0);

  always_comb begin
    pick     = fwd;
    next_col = col;
    if (has_up && up < fwd && (!has_dn || up <= e_q)) begin
      pick     = up;
      next_col = col + 1'b1;
    end else if (has_dn && e_q < fwd) begin
      pick     = e_q;
      next_col = col - 1'b1;
    end
  end

  assign tot_new   = total + TOTAL_W'(pick);
  assign row_end   = {1'b0, row} == jh - 7'd1;
  assign start_end = {1'b0, start} == jw - 7'd1;
  assign better    = (start == '0) || (tot_new < best_total);
  assign nb_total  = better ? tot_new : best_total;
  assign nb_start  = better ? start : best_start;
  assign step_end  = (state == B_WALK) && (ph == PH_3);
  assign emit_load = (state == B_EMIT_WT) && (!ovalid || pop);

  assign job_pop     = (state == B_IDLE) && !jq_empty;
  assign pix_release = e_we && last_pix;
  assign empty       = ~ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:    if (!jq_empty) state_next = B_ENERGY;
      B_ENERGY:  if (pix_release) state_next = B_WALK;
      B_WALK:    if (step_end && row_end && recording) state_next = B_EMIT_RD;
      B_EMIT_RD: state_next = B_EMIT_WT;
      B_EMIT_WT: begin
        if (emit_load) begin
          state_next = ({1'b0, k} == jh - 7'd1) ? B_IDLE : B_EMIT_RD;
        end
      end
      default:   state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit_load) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        jw   <= job.w;
        jh   <= job.h;
        er   <= '0;
        ec   <= '0;
        eidx <= '0;
        ph   <= PH_0;
      end
      B_ENERGY: begin
        ph <= (ph == PH_4) ? PH_0 : ph + 3'd1;
        if (ph == PH_1) pa <= pix_q;
        if (ph == PH_2) hsum <= sq_diff(pa, pix_q);
        if (ph == PH_3) pc <= pix_q;
        if (ph == PH_4) begin
          eidx <= eidx + 1'b1;
          if ({1'b0, ec} == jw - 7'd1) begin
            ec <= '0;
            er <= er + 1'b1;
          end else begin
            ec <= ec + 1'b1;
          end
          start     <= '0;
          col       <= '0;
          row       <= '0;
          total     <= '0;
          recording <= 1'b0;
        end
      end
      B_WALK: begin
        ph <= (ph == PH_3) ? PH_0 : ph + 3'd1;
        if (ph == PH_1) fwd <= e_q;
        if (ph == PH_2) up <= e_q;
        if (ph == PH_3) begin
          col <= next_col;
          if (!row_end) begin
            row   <= row + 1'b1;
            total <= tot_new;
          end else begin
            row   <= '0;
            total <= '0;
            k     <= '0;
            if (!recording) begin
              best_total <= nb_total;
              best_start <= nb_start;
              if (start_end) begin
                recording <= 1'b1;
                col       <= nb_start;
              end else begin
                start <= start + 1'b1;
                col   <= start + 1'b1;
              end
            end
          end
        end
      end
      B_EMIT_RD: begin
      end
      B_EMIT_WT: begin
        if (emit_load) begin
          seam_column       <= path_q;
          seam_row          <= k;
          seam_total_energy <= best_total;
          last_row          <= {1'b0, k} == jh - 7'd1;
          k                 <= k + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      emem[eidx] <= e_wdata;
    end
    e_q <= emem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (step_end && recording) begin
      path[row] <= next_col;
    end
    path_q <= path[k];
  end

endmodule
